### rtl/lcss_pkg.sv
package lcss_pkg;

  typedef enum logic [23:0] {
    ST_IDLE    = 24'h000001,
    ST_BUSY    = 24'h000002,
    ST_CMOD    = 24'h000004,
    ST_RMOD    = 24'h000008,
    ST_EE_TEST = 24'h000010,
    ST_EE_Q    = 24'h000020,
    ST_EE_S    = 24'h000040,
    ST_EE_MG   = 24'h000080,
    ST_EE_SM   = 24'h000100,
    ST_RG      = 24'h000200,
    ST_P       = 24'h000400,
    ST_A2      = 24'h000800,
    ST_M1P     = 24'h001000,
    ST_A1      = 24'h002000,
    ST_DG      = 24'h004000,
    ST_M2G     = 24'h008000,
    ST_T       = 24'h010000,
    ST_OVC     = 24'h020000,
    ST_NM      = 24'h040000,
    ST_NR      = 24'h080000,
    ST_LEAST   = 24'h100000,
    ST_K       = 24'h200000,
    ST_L       = 24'h400000,
    ST_FIN     = 24'h800000
  } state_t;

  // shared unit operations
  typedef enum logic [2:0] {
    OP_DIV    = 3'b001,
    OP_MUL    = 3'b010,
    OP_MULMOD = 3'b100
  } op_t;

  typedef struct packed {
    logic   en;
    op_t    op;
    state_t ret;
  } issue_t;

endpackage

### rtl/linear_congruence_system_solver_unit.sv
// Each operation runs on the bit-serial shared divide/multiply unit; an item runs a sequence
// of such operations, including the Euclid division steps over both gcd passes.
// Throughput: one item at a time; in_stall is high until the result beat is taken.
// Reset (rst, synchronous): system x = 0 mod 1, bound 0, failure and overflow clear.
module linear_congruence_system_solver_unit import lcss_pkg::*; #(
  parameter int VALUE_WIDTH = 62
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   start_req,
  input  logic [VALUE_WIDTH-1:0] coeff,
  input  logic [VALUE_WIDTH-1:0] rhs,
  input  logic [VALUE_WIDTH-1:0] modulus,
  input  logic [VALUE_WIDTH-1:0] min_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   ok,
  output logic                   overflow,
  output logic [VALUE_WIDTH-1:0] residue,
  output logic [VALUE_WIDTH-1:0] combined_modulus,
  output logic [VALUE_WIDTH-1:0] least_solution
);

  localparam int W  = VALUE_WIDTH;
  localparam int NW = VALUE_WIDTH + 2;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam logic [W-1:0] MAXV = {W{1'b1}};

  state_t state, ret;
  op_t    uop;
  issue_t iss;
  logic [NW-1:0] iss_x;
  logic [W-1:0]  iss_y, iss_m;

  // shared unit registers
  logic [NW-1:0] ua, uacc;
  logic [W-1:0]  ub, um;
  logic [CW-1:0] cnt;
  logic [NW-1:0] ua_next, uacc_next;
  logic [W-1:0]  ub_next;

  // architectural state
  logic [W-1:0] sres, smod, bound;
  logic         failed, ovf;

  // working registers
  logic [W-1:0]  cv, rv, pm, pv, a2, rg, dq, g2, s2, m2g, tv, newmod, em, emg, sv;
  logic [NW-1:0] e_r0, e_r1, e_s0, e_s1, least;
  logic          phase, sneg;

  logic [W:0]    dv_t, mm_sum, mm_dbl, diff_w;
  logic          dv_ge;
  logic [NW-1:0] s0_abs, least_sum;
  logic [W-1:0]  div_q, div_r, bnd_base, k;
  logic          accept, active;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign active   = start_req || (!failed && !ovf);
  assign bnd_base = start_req ? '0 : bound;
  assign div_q    = ub;
  assign div_r    = uacc[W-1:0];
  assign s0_abs   = e_s0[NW-1] ? (~e_s0 + 1'b1) : e_s0;
  assign diff_w   = (a2 >= div_r) ? ({1'b0, a2} - {1'b0, div_r})
                                  : ({1'b0, a2} + {1'b0, pv} - {1'b0, div_r});
  assign k        = div_q + {{(W-1){1'b0}}, (div_r != '0)};
  assign least_sum = {2'b00, sres} + uacc;

  // one step of the bit-serial unit
  always_comb begin
    dv_t      = {uacc[W-1:0], ub[W-1]};
    dv_ge     = dv_t >= {1'b0, um};
    mm_sum    = {1'b0, uacc[W-1:0]} + {1'b0, ua[W-1:0]};
    mm_dbl    = {ua[W-1:0], 1'b0};
    ua_next   = ua;
    ub_next   = ub;
    uacc_next = uacc;
    unique case (uop)
      OP_DIV: begin
        uacc_next = {2'b00, dv_ge ? dv_t[W-1:0] - um : dv_t[W-1:0]};
        ub_next   = {ub[W-2:0], dv_ge};
      end
      OP_MUL: begin
        if (ub[0]) uacc_next = uacc + ua;
        ua_next = {ua[NW-2:0], 1'b0};
        ub_next = {1'b0, ub[W-1:1]};
      end
      OP_MULMOD: begin
        if (ub[0]) begin
          uacc_next = {2'b00, (mm_sum >= {1'b0, um}) ? mm_sum[W-1:0] - um : mm_sum[W-1:0]};
        end
        ua_next = {2'b00, (mm_dbl >= {1'b0, um}) ? mm_dbl[W-1:0] - um : mm_dbl[W-1:0]};
        ub_next = {1'b0, ub[W-1:1]};
      end
      default: ;
    endcase
  end

  // operation issue from the sequencer
  always_comb begin
    iss   = '{en: 1'b0, op: OP_DIV, ret: ST_IDLE};
    iss_x = '0;
    iss_y = '0;
    iss_m = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && active && modulus != '0) begin
          iss = '{en: 1'b1, op: OP_DIV, ret: ST_CMOD};
          iss_x = {2'b00, coeff};
          iss_y = modulus;
        end
      end
      ST_CMOD: begin
        iss = '{en: 1'b1, op: OP_DIV, ret: ST_RMOD};
        iss_x = {2'b00, rv};
        iss_y = pm;
      end
      ST_EE_TEST: begin
        if (e_r1 == '0) begin
          iss = '{en: 1'b1, op: OP_DIV, ret: ST_EE_MG};
          iss_x = {2'b00, em};
          iss_y = e_r0[W-1:0];
        end else begin
          iss = '{en: 1'b1, op: OP_DIV, ret: ST_EE_Q};
          iss_x = e_r0;
          iss_y = e_r1[W-1:0];
        end
      end
      ST_EE_Q: begin
        iss = '{en: 1'b1, op: OP_MUL, ret: ST_EE_S};
        iss_x = e_s1;
        iss_y = div_q;
      end
      ST_EE_MG: begin
        iss = '{en: 1'b1, op: OP_DIV, ret: ST_EE_SM};
        iss_x = {2'b00, s0_abs[W-1:0]};
        iss_y = div_q;
      end
      ST_EE_SM: begin
        if (!phase) begin
          iss = '{en: 1'b1, op: OP_DIV, ret: ST_RG};
          iss_x = {2'b00, rv};
          iss_y = e_r0[W-1:0];
        end else begin
          iss = '{en: 1'b1, op: OP_DIV, ret: ST_A1};
          iss_x = {2'b00, sres};
          iss_y = pv;
        end
      end
      ST_RG: begin
        if (div_r == '0) begin
          iss = '{en: 1'b1, op: OP_DIV, ret: ST_P};
          iss_x = {2'b00, pm};
          iss_y = e_r0[W-1:0];
        end
      end
      ST_P: begin
        iss = '{en: 1'b1, op: OP_MULMOD, ret: ST_A2};
        iss_x = {2'b00, rg};
        iss_y = sv;
        iss_m = div_q;
      end
      ST_A2: begin
        iss = '{en: 1'b1, op: OP_DIV, ret: ST_M1P};
        iss_x = {2'b00, smod};
        iss_y = pv;
      end
      ST_A1: begin
        iss = '{en: 1'b1, op: OP_DIV, ret: ST_DG};
        iss_x = {2'b00, diff_w[W-1:0]};
        iss_y = g2;
      end
      ST_DG: begin
        if (div_r == '0) begin
          iss = '{en: 1'b1, op: OP_DIV, ret: ST_M2G};
          iss_x = {2'b00, pv};
          iss_y = g2;
        end
      end
      ST_M2G: begin
        iss = '{en: 1'b1, op: OP_MULMOD, ret: ST_T};
        iss_x = {2'b00, dq};
        iss_y = s2;
        iss_m = div_q;
      end
      ST_T: begin
        iss = '{en: 1'b1, op: OP_DIV, ret: ST_OVC};
        iss_x = {2'b00, MAXV};
        iss_y = m2g;
      end
      ST_OVC: begin
        if (smod <= div_q) begin
          iss = '{en: 1'b1, op: OP_MUL, ret: ST_NM};
          iss_x = {2'b00, smod};
          iss_y = m2g;
        end
      end
      ST_NM: begin
        iss = '{en: 1'b1, op: OP_MUL, ret: ST_NR};
        iss_x = {2'b00, smod};
        iss_y = tv;
      end
      ST_LEAST: begin
        if (bound > sres) begin
          iss = '{en: 1'b1, op: OP_DIV, ret: ST_K};
          iss_x = {2'b00, bound - sres};
          iss_y = smod;
        end
      end
      ST_K: begin
        iss = '{en: 1'b1, op: OP_MUL, ret: ST_L};
        iss_x = {2'b00, smod};
        iss_y = k;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ret    <= ST_IDLE;
      uop    <= OP_DIV;
      cnt    <= '0;
      sres   <= '0;
      smod   <= {{(W-1){1'b0}}, 1'b1};
      bound  <= '0;
      failed <= 1'b0;
      ovf    <= 1'b0;
    end else begin
      if (iss.en) begin
        state <= ST_BUSY;
        ret   <= iss.ret;
        uop   <= iss.op;
        cnt   <= '0;
        ua    <= iss_x;
        uacc  <= '0;
        if (iss.op == OP_DIV) begin
          ub <= iss_x[W-1:0];
          um <= iss_y;
        end else begin
          ub <= iss_y;
          um <= iss_m;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (start_req) begin
              sres   <= '0;
              smod   <= {{(W-1){1'b0}}, 1'b1};
              ovf    <= 1'b0;
            end
            failed <= (failed && !start_req) || (active && modulus == '0);
            bound <= (min_value > bnd_base) ? min_value : bnd_base;
            rv    <= rhs;
            pm    <= modulus;
            least <= '0;
            if (!active) begin
              state <= ST_FIN;
            end else if (modulus == '0) begin
              state  <= ST_FIN;
            end
          end
        end
        ST_BUSY: begin
          ua   <= ua_next;
          ub   <= ub_next;
          uacc <= uacc_next;
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) state <= ret;
        end
        ST_CMOD: cv <= div_r;
        ST_RMOD: begin
          rv    <= div_r;
          e_r0  <= {2'b00, cv};
          e_r1  <= {2'b00, pm};
          e_s0  <= {{(NW-1){1'b0}}, 1'b1};
          e_s1  <= '0;
          em    <= pm;
          phase <= 1'b0;
          state <= ST_EE_TEST;
        end
        ST_EE_Q: begin
          e_r0 <= e_r1;
          e_r1 <= {2'b00, div_r};
        end
        ST_EE_S: begin
          e_s0  <= e_s1;
          e_s1  <= e_s0 - uacc;
          state <= ST_EE_TEST;
        end
        ST_EE_MG: begin
          emg  <= div_q;
          sneg <= e_s0[NW-1];
        end
        ST_EE_SM: begin
          // s0 mod m/g, brought to the nonnegative range
          sv <= (sneg && div_r != '0) ? emg - div_r : div_r;
          if (phase) begin
            g2 <= e_r0[W-1:0];
            s2 <= (sneg && div_r != '0) ? emg - div_r : div_r;
          end
        end
        ST_RG: begin
          rg <= div_q;
          if (div_r != '0) begin
            failed <= 1'b1;
            state  <= ST_FIN;
          end
        end
        ST_P: pv <= div_q;
        ST_A2: a2 <= uacc[W-1:0];
        ST_M1P: begin
          e_r0  <= {2'b00, div_r};
          e_r1  <= {2'b00, pv};
          e_s0  <= {{(NW-1){1'b0}}, 1'b1};
          e_s1  <= '0;
          em    <= pv;
          phase <= 1'b1;
          state <= ST_EE_TEST;
        end
        ST_A1: ;
        ST_DG: begin
          dq <= div_q;
          if (div_r != '0) begin
            failed <= 1'b1;
            state  <= ST_FIN;
          end
        end
        ST_M2G: m2g <= div_q;
        ST_T: tv <= uacc[W-1:0];
        ST_OVC: begin
          if (smod > div_q) begin
            ovf   <= 1'b1;
            state <= ST_FIN;
          end
        end
        ST_NM: newmod <= uacc[W-1:0];
        ST_NR: begin
          sres  <= sres + uacc[W-1:0];
          smod  <= newmod;
          state <= ST_LEAST;
        end
        ST_LEAST: begin
          if (bound <= sres) begin
            least <= {2'b00, sres};
            state <= ST_FIN;
          end
        end
        ST_K: ;
        ST_L: begin
          least <= least_sum;
          if (least_sum > {2'b00, MAXV}) ovf <= 1'b1;
          state <= ST_FIN;
        end
        ST_EE_TEST: ;
        ST_FIN: begin
          if (!out_stall) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_valid        = (state == ST_FIN);
  assign ok               = !failed && !ovf;
  assign overflow         = ovf;
  assign residue          = ok ? sres : '0;
  assign combined_modulus = ok ? smod : '0;
  assign least_solution   = ok ? least[W-1:0] : '0;

endmodule
